FILE: design/gbap_pkg.sv
// Shared constants, types and command structures of the grid block average pixelator.
package gbap_pkg;

    localparam int GRID_COLS = 10;
    localparam int GRID_ROWS = 10;
    localparam int MAX_DIM   = 4096;
    localparam int SUM_WIDTH = 32;

    localparam int NCELLS    = GRID_COLS * GRID_ROWS;
    localparam int CELL_W    = $clog2(NCELLS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);

    localparam int DIM_CFG_W = 13;
    localparam int CHAN_W    = 3;
    localparam int SCALE_W   = 25;
    localparam int SEL_W     = 7;
    localparam int SAMPLE_W  = 8;
    localparam int LEVEL_W   = 17;
    localparam int PIXEL_W   = 8;

    localparam int POS_W     = $clog2(MAX_DIM);
    localparam int CDIM_W    = $clog2(MAX_DIM + 1);
    localparam int CMP_W     = CDIM_W + 1;

    // Division of a clamped dimension by the grid size is a multiply by a reciprocal.
    localparam int DIV_SHIFT = CDIM_W + 5;
    localparam int COL_RECIP = ((2 ** DIV_SHIFT) + GRID_COLS - 1) / GRID_COLS;
    localparam int ROW_RECIP = ((2 ** DIV_SHIFT) + GRID_ROWS - 1) / GRID_ROWS;
    localparam int RECIP_W   = DIV_SHIFT + 1;

    localparam int PROD_W    = SUM_WIDTH + SCALE_W;
    localparam int Q_W       = PROD_W - 16;
    localparam int LEVEL_MAX = 65536;
    localparam int PIXEL_MAX = 255;

    localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = DIM_CFG_W'(640);
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = DIM_CFG_W'(480);
    localparam logic [CHAN_W-1:0]    CHAN_RST   = CHAN_W'(1);
    localparam logic [SCALE_W-1:0]   SCALE_RST  = SCALE_W'(5461);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_CHAN   = 2'd2,
        REG_SCALE  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_ACC    = 2'd1,
        FUNC_LEVEL  = 2'd2,
        FUNC_REPLAY = 2'd3
    } t_func;

    typedef struct packed {
        logic [DIM_CFG_W-1:0] width;
        logic [DIM_CFG_W-1:0] height;
        logic [CHAN_W-1:0]    chan;
        logic [SCALE_W-1:0]   scale;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

FILE: design/gbap_regs.sv
// Configuration register file with its APB-style access port.
module gbap_regs import gbap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
            r_cfg.chan   <= CHAN_RST;
            r_cfg.scale  <= SCALE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WIDTH:  r_cfg.width  <= pwdata[DIM_CFG_W-1:0];
                REG_HEIGHT: r_cfg.height <= pwdata[DIM_CFG_W-1:0];
                REG_CHAN:   r_cfg.chan   <= pwdata[CHAN_W-1:0];
                REG_SCALE:  r_cfg.scale  <= pwdata[SCALE_W-1:0];
                default:    r_cfg.scale  <= r_cfg.scale;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WIDTH:  prdata = 32'(r_cfg.width);
            REG_HEIGHT: prdata = 32'(r_cfg.height);
            REG_CHAN:   prdata = 32'(r_cfg.chan);
            REG_SCALE:  prdata = 32'(r_cfg.scale);
            default:    prdata = 32'd0;
        endcase
    end

endmodule

FILE: design/gbap_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module gbap_ctrl import gbap_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_EMIT
    } t_state;

    t_state r_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.read = (r_state == ST_READ);
        o_cmd.exec = (r_state == ST_EXEC);
        o_cmd.push = (r_state == ST_EMIT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_READ;
                end
                ST_READ: r_state <= ST_EXEC;
                ST_EXEC: r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (i_stat.out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: design/gbap_dp.sv
// Datapath: cell sum memory, raster position counters, scaling multiplier and result register.
module gbap_dp import gbap_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [1:0]          i_func,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SEL_W-1:0]    i_sel,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [LEVEL_W-1:0]  o_level,
    output logic [PIXEL_W-1:0]  o_pixel,
    output logic                o_done
);

    logic [SUM_WIDTH-1:0] r_mem [NCELLS];
    logic [NCELLS-1:0]    r_valid;

    t_func                r_func;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [SEL_W-1:0]     r_sel;
    logic                 r_sel_ok;
    logic [CELL_W-1:0]    r_addr;
    logic [SUM_WIDTH-1:0] r_rd_q;
    logic                 r_vld_q;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_wrap;

    logic [POS_W-1:0]     r_pos_row, r_pos_col, r_col_in, r_row_in;
    logic [1:0]           r_pos_chan;
    logic [COL_W-1:0]     r_cell_col;
    logic [ROW_W-1:0]     r_cell_row;

    logic [POS_W-1:0]     n_pos_row, n_pos_col, n_col_in, n_row_in;
    logic [1:0]           n_pos_chan;
    logic [COL_W-1:0]     n_cell_col;
    logic [ROW_W-1:0]     n_cell_row;
    logic                 n_wrap;

    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_level;
    logic [PIXEL_W-1:0]   r_pixel;
    logic                 r_done;

    logic [DIM_CFG_W:0]   w_wide_w, w_wide_h;
    logic [CDIM_W-1:0]    w_w, w_h;
    logic [CHAN_W-1:0]    w_ch;
    logic [CDIM_W+RECIP_W-1:0] w_xprod, w_yprod;
    logic [CMP_W-1:0]     w_per_x, w_per_y;
    logic [CELL_W-1:0]    w_cur_cell, w_addr;
    logic [SUM_WIDTH-1:0] w_sum;
    logic [SUM_WIDTH:0]   w_add;
    logic [SUM_WIDTH-1:0] w_sat;
    logic [Q_W-1:0]       w_q;
    logic [Q_W-9:0]       w_q8;
    logic                 w_adv;

    always_comb begin
        w_wide_w = {1'b0, i_cfg.width};
        w_wide_h = {1'b0, i_cfg.height};
        if (i_cfg.width == '0) begin
            w_w = CDIM_W'(1);
        end else if (w_wide_w > (DIM_CFG_W+1)'(MAX_DIM)) begin
            w_w = CDIM_W'(MAX_DIM);
        end else begin
            w_w = CDIM_W'(w_wide_w);
        end
        if (i_cfg.height == '0) begin
            w_h = CDIM_W'(1);
        end else if (w_wide_h > (DIM_CFG_W+1)'(MAX_DIM)) begin
            w_h = CDIM_W'(MAX_DIM);
        end else begin
            w_h = CDIM_W'(w_wide_h);
        end
        if (i_cfg.chan == '0) begin
            w_ch = CHAN_W'(1);
        end else if (i_cfg.chan > CHAN_W'(4)) begin
            w_ch = CHAN_W'(4);
        end else begin
            w_ch = i_cfg.chan;
        end
        w_xprod = (CDIM_W+RECIP_W)'(w_w) * (CDIM_W+RECIP_W)'(COL_RECIP);
        w_yprod = (CDIM_W+RECIP_W)'(w_h) * (CDIM_W+RECIP_W)'(ROW_RECIP);
        w_per_x = CMP_W'(w_xprod >> DIV_SHIFT) + CMP_W'(1);
        w_per_y = CMP_W'(w_yprod >> DIV_SHIFT) + CMP_W'(1);
    end

    always_comb begin
        n_pos_row  = r_pos_row;
        n_pos_col  = r_pos_col;
        n_pos_chan = r_pos_chan;
        n_col_in   = r_col_in;
        n_row_in   = r_row_in;
        n_cell_col = r_cell_col;
        n_cell_row = r_cell_row;
        n_wrap     = 1'b0;
        if (CHAN_W'(r_pos_chan) + CHAN_W'(1) < w_ch) begin
            n_pos_chan = r_pos_chan + 2'd1;
        end else begin
            n_pos_chan = 2'd0;
            if (CMP_W'(r_pos_col) + CMP_W'(1) < CMP_W'(w_w)) begin
                n_pos_col = r_pos_col + POS_W'(1);
                if (CMP_W'(r_col_in) + CMP_W'(1) < w_per_x) begin
                    n_col_in = r_col_in + POS_W'(1);
                end else begin
                    n_col_in = '0;
                    if (32'(r_cell_col) + 32'd1 < 32'(GRID_COLS)) begin
                        n_cell_col = r_cell_col + COL_W'(1);
                    end
                end
            end else begin
                n_pos_col  = '0;
                n_col_in   = '0;
                n_cell_col = '0;
                if (CMP_W'(r_pos_row) + CMP_W'(1) < CMP_W'(w_h)) begin
                    n_pos_row = r_pos_row + POS_W'(1);
                    if (CMP_W'(r_row_in) + CMP_W'(1) < w_per_y) begin
                        n_row_in = r_row_in + POS_W'(1);
                    end else begin
                        n_row_in = '0;
                        if (32'(r_cell_row) + 32'd1 < 32'(GRID_ROWS)) begin
                            n_cell_row = r_cell_row + ROW_W'(1);
                        end
                    end
                end else begin
                    n_pos_row  = '0;
                    n_row_in   = '0;
                    n_cell_row = '0;
                    n_wrap     = 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_cur_cell = CELL_W'(32'(r_cell_row) * GRID_COLS + 32'(r_cell_col));
        w_addr     = (r_func == FUNC_LEVEL) ? CELL_W'(r_sel) : w_cur_cell;
        w_sum      = r_vld_q ? r_rd_q : '0;
        w_add      = {1'b0, w_sum} + (SUM_WIDTH+1)'(r_sample);
        w_sat      = w_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : w_add[SUM_WIDTH-1:0];
        w_q        = r_prod[PROD_W-1:16];
        w_q8       = w_q[Q_W-1:8];
        w_adv      = (r_func == FUNC_ACC) || (r_func == FUNC_REPLAY);
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_level         = r_level;
    assign o_pixel         = r_pixel;
    assign o_done          = r_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= t_func'(i_func);
            r_sample <= i_sample;
            r_sel    <= i_sel;
            r_sel_ok <= ({2'b00, i_sel} < 9'(NCELLS));
        end
        if (i_cmd.read) begin
            r_addr  <= w_addr;
            r_rd_q  <= r_mem[w_addr];
            r_vld_q <= r_valid[w_addr];
        end
        if (i_cmd.exec) begin
            r_prod <= PROD_W'(w_sum) * PROD_W'(i_cfg.scale);
            if (r_func == FUNC_ACC) begin
                r_mem[r_addr] <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_pos_row  <= '0;
            r_pos_col  <= '0;
            r_pos_chan <= '0;
            r_col_in   <= '0;
            r_row_in   <= '0;
            r_cell_col <= '0;
            r_cell_row <= '0;
            r_wrap     <= 1'b0;
        end else if (i_cmd.exec) begin
            if (r_func == FUNC_START) begin
                r_valid    <= '0;
                r_pos_row  <= '0;
                r_pos_col  <= '0;
                r_pos_chan <= '0;
                r_col_in   <= '0;
                r_row_in   <= '0;
                r_cell_col <= '0;
                r_cell_row <= '0;
                r_wrap     <= 1'b0;
            end else if (w_adv) begin
                if (r_func == FUNC_ACC) begin
                    r_valid[r_addr] <= 1'b1;
                end
                r_pos_row  <= n_pos_row;
                r_pos_col  <= n_pos_col;
                r_pos_chan <= n_pos_chan;
                r_col_in   <= n_col_in;
                r_row_in   <= n_row_in;
                r_cell_col <= n_cell_col;
                r_cell_row <= n_cell_row;
                r_wrap     <= n_wrap;
            end else begin
                r_wrap <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_level <= '0;
            r_pixel <= '0;
            r_done  <= w_adv && r_wrap;
            if (r_func == FUNC_LEVEL && r_sel_ok) begin
                r_level <= (w_q > Q_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(w_q);
            end
            if (r_func == FUNC_REPLAY) begin
                r_pixel <= (w_q8 > (Q_W-8)'(PIXEL_MAX)) ? PIXEL_W'(PIXEL_MAX)
                                                        : PIXEL_W'(w_q8);
            end
        end
    end

endmodule

FILE: design/grid_block_average_pixelator_unit.sv
// Top level of the grid block average pixelator: registers, controller and datapath.
//
//  Port group   Direction  Contents
//  s_axis       in         tdata: sample_in[7:0], cell_select[14:8]; tuser: func[1:0]
//  m_axis       out        tdata: cell_level[16:0], pixel_value[24:17]; tlast: frame_done
//  APB          in/out     four configuration registers at byte addresses 0, 4, 8, 12
//
// Every transaction passes in order through accept, cell memory read, sum update or
// scaling multiply, and result load into the output register.
// A new transaction is accepted while the previous result waits in the output register;
// a stalled output holds the controller in its last step until the register frees up.
// Reset is synchronous and active low; it clears all cell sums through per-cell valid bits.
module grid_block_average_pixelator_unit import gbap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // sample_in, cell_select, zero pad
    input  logic [1:0]  i_s_axis_tuser,   // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // cell_level, pixel_value, zero pad
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg               w_cfg;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [LEVEL_W-1:0] w_level;
    logic [PIXEL_W-1:0] w_pixel;

    gbap_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gbap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gbap_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_func      (i_s_axis_tuser),
        .i_sample    (i_s_axis_tdata[SAMPLE_W-1:0]),
        .i_sel       (i_s_axis_tdata[SAMPLE_W+SEL_W-1:SAMPLE_W]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_level     (w_level),
        .o_pixel     (w_pixel),
        .o_done      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, w_pixel, w_level};

endmodule
